// File: hw/rtl/pse_pkg.sv
// Shared types, constants and status codes for the postfix stack evaluator.
// No dependencies.
`timescale 1ns / 1ps
package pse_pkg;
  localparam int StackDepth = 64;
  localparam int FracBits   = 16;
  localparam int ValW       = 48;
  localparam int AddrW      = $clog2(StackDepth);
  localparam int CntW       = $clog2(StackDepth + 1);

  localparam logic [7:0] OpAdd = 8'h2B;
  localparam logic [7:0] OpSub = 8'h2D;
  localparam logic [7:0] OpMul = 8'h2A;
  localparam logic [7:0] OpDiv = 8'h2F;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_DIVZ  = 3'd2,
    ST_BADOP = 3'd3,
    ST_LEFT  = 3'd4,
    ST_FULL  = 3'd5,
    ST_SAT   = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RDR, S_RDL, S_EXEC, S_MUL, S_DIV, S_FIN, S_OUT
  } state_t;

  // Saturate a sign/magnitude value (magnitude may exceed 48 bits) to 48 bits.
  function automatic logic [ValW:0] sat_mag(input logic neg, input logic [96:0] mag);
    logic [ValW-1:0] v;
    logic            s;
    s = 1'b0;
    if (neg) begin
      if (mag > 97'h800000000000) begin
        v = 48'h800000000000; s = 1'b1;
      end else begin
        v = 48'(-mag[47:0]);
      end
    end else begin
      if (mag > 97'h7FFFFFFFFFFF) begin
        v = 48'h7FFFFFFFFFFF; s = 1'b1;
      end else begin
        v = mag[47:0];
      end
    end
    return {s, v};
  endfunction
endpackage

// File: hw/rtl/pse_if.sv
// Valid/ready channel interface carrying request or result payloads.
// Depends on nothing.
`timescale 1ns / 1ps
interface pse_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic signed [31:0] number;
  logic [7:0]  operator_char;
  logic        last_token;
  modport source (output valid, req_type, number, operator_char, last_token, input ready);
  modport sink   (input valid, req_type, number, operator_char, last_token, output ready);
endinterface

interface pse_out_if;
  logic        valid;
  logic        ready;
  logic signed [47:0] value;
  logic [2:0]  status;
  logic        final_res;
  modport source (output valid, value, status, final_res, input ready);
  modport sink   (input valid, value, status, final_res, output ready);
endinterface

// File: hw/rtl/postfix_stack_evaluator_top.sv
// Postfix evaluator top: sequencer, stack memory, multiplier, divider.
// Depends on pse_pkg, pse_if, pse_stack_ram, pse_divider.
`timescale 1ns / 1ps
//  channel | dir | payload
//  in_ch   | in  | req_type, number, operator_char, last_token
//  out_ch  | out | value, status, final_res
// One request at a time; in_ready is high only while idle.
// Push, add, subtract, errors and ignored requests: the request passes S_RDR,
// S_RDL, S_EXEC and S_FIN, then the result is held in S_OUT. Multiply adds four
// 24x24 partial products in S_MUL, one a cycle, then saturates. Divide waits in
// S_DIV on the bit-serial divider (64 quotient bits).
// Reset clears count, error flag and state; memory contents stay undefined.
// A stalled out_ready holds the result; in_ready stays low until it is taken.
module postfix_stack_evaluator_top
  import pse_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pse_in_if.sink    in_ch,
  pse_out_if.source out_ch
);
  localparam int HalfW = ValW / 2;
  localparam int MulW  = 2 * ValW;
  localparam logic [2:0]      MulSteps = 3'd4;
  localparam logic [ValW-1:0] MaxVal   = {1'b0, {(ValW-1){1'b1}}};
  localparam logic [ValW-1:0] MinVal   = {1'b1, {(ValW-1){1'b0}}};

  state_t          state_r, state_nxt;
  logic [CntW-1:0] cnt_r;
  logic            err_r;
  logic            req_r, last_r;
  logic [31:0]     num_r;
  logic [7:0]      op_r;
  logic [ValW-1:0] rhs_r, lhs_r;
  logic [ValW-1:0] res_r;
  logic            sat_r;
  status_t         st_r;
  logic [MulW-1:0] prod_r;
  logic [2:0]      mul_idx_r;
  logic            neg_r;
  logic [ValW-1:0] val_o_r;
  status_t         st_o_r;
  logic            fin_o_r;

  logic               we;
  logic [AddrW-1:0]   waddr, raddr;
  logic [ValW-1:0]    rdata;
  logic               div_start, div_done, div_ovf;
  logic [ValW-1:0]    div_q, amag, bmag;
  logic               op_ok, go_mul, go_div;
  logic signed [63:0] push_w;
  logic               push_ovf;
  logic [ValW-1:0]    push_val;
  logic [ValW:0]      sum_w;
  logic               sum_ovf;
  logic [ValW-1:0]    sum_val;
  logic [HalfW-1:0]   a_part, b_part;
  logic [ValW-1:0]    pp;
  logic [MulW-1:0]    pp_sh;
  status_t            exec_st;
  logic [ValW-1:0]    exec_res;
  logic               exec_sat;
  logic               ok_fin, left_over;
  logic [CntW-1:0]    cnt_upd;

  pse_stack_ram u_ram (.clk, .we, .waddr, .wdata(res_r), .raddr, .rdata);

  assign amag = lhs_r[ValW-1] ? ValW'(-lhs_r) : lhs_r;
  assign bmag = rhs_r[ValW-1] ? ValW'(-rhs_r) : rhs_r;

  pse_divider u_div (.clk, .rst_n, .start(div_start), .num_mag(amag), .den_mag(bmag),
                     .done(div_done), .quot(div_q), .ovf(div_ovf));

  assign out_ch.value     = val_o_r;
  assign out_ch.status    = st_o_r;
  assign out_ch.final_res = fin_o_r;

  // operator gating
  assign op_ok  = !err_r && req_r && (cnt_r >= CntW'(2));
  assign go_mul = op_ok && (op_r == OpMul);
  assign go_div = op_ok && (op_r == OpDiv) && (rhs_r != '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_ch.valid) state_nxt = S_RDR;
      S_RDR:  state_nxt = S_RDL;
      S_RDL:  state_nxt = S_EXEC;
      S_EXEC: begin
        if (go_mul) state_nxt = S_MUL;
        else if (go_div) state_nxt = S_DIV;
        else state_nxt = S_FIN;
      end
      S_MUL:  if (mul_idx_r == MulSteps) state_nxt = S_FIN;
      S_DIV:  if (div_done) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_OUT;
      S_OUT:  if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // handshakes, memory control and divider start
  always_comb begin
    in_ch.ready  = (state_r == S_IDLE);
    out_ch.valid = (state_r == S_OUT);
    raddr = (state_r == S_RDR) ? AddrW'(cnt_r - CntW'(2)) : AddrW'(cnt_r - CntW'(1));
    we    = (state_r == S_FIN) && ok_fin;
    waddr = req_r ? AddrW'(cnt_r - CntW'(2)) : AddrW'(cnt_r);
    div_start = (state_r == S_EXEC) && go_div;
  end

  // push value: integer to fixed point, clamped to the value range
  assign push_w   = 64'(signed'(num_r)) <<< FracBits;
  assign push_ovf = !((&push_w[63:ValW-1]) || !(|push_w[63:ValW-1]));
  assign push_val = push_ovf ? (push_w[63] ? MinVal : MaxVal) : push_w[ValW-1:0];

  // add or subtract with one guard bit, clamp on overflow
  assign sum_w   = (op_r == OpSub) ? ({lhs_r[ValW-1], lhs_r} - {rhs_r[ValW-1], rhs_r})
                                   : ({lhs_r[ValW-1], lhs_r} + {rhs_r[ValW-1], rhs_r});
  assign sum_ovf = sum_w[ValW] ^ sum_w[ValW-1];
  assign sum_val = sum_ovf ? (sum_w[ValW] ? MinVal : MaxVal) : sum_w[ValW-1:0];

  // one half-width partial product per multiply step
  assign a_part = mul_idx_r[0] ? amag[ValW-1:HalfW] : amag[HalfW-1:0];
  assign b_part = mul_idx_r[1] ? bmag[ValW-1:HalfW] : bmag[HalfW-1:0];
  assign pp     = a_part * b_part;

  always_comb begin
    case (mul_idx_r[1:0])
      2'd0:    pp_sh = MulW'(pp);
      2'd3:    pp_sh = MulW'(pp) << ValW;
      default: pp_sh = MulW'(pp) << HalfW;
    endcase
  end

  // classify the request once both operands are in
  always_comb begin
    exec_st  = ST_OK;
    exec_res = '0;
    exec_sat = 1'b0;
    if (!err_r) begin
      if (!req_r) begin
        if (cnt_r == CntW'(StackDepth)) begin
          exec_st = ST_FULL;
        end else begin
          exec_res = push_val;
          exec_sat = push_ovf;
        end
      end else if (cnt_r < CntW'(2)) begin
        exec_st = ST_UNDER;
      end else begin
        case (op_r)
          OpAdd, OpSub: begin
            exec_res = sum_val;
            exec_sat = sum_ovf;
          end
          OpMul: exec_st = ST_OK;
          OpDiv: if (rhs_r == '0) exec_st = ST_DIVZ;
          default: exec_st = ST_BADOP;
        endcase
      end
    end
  end

  // stack count after the request and the leftover check on the last token
  assign ok_fin    = !err_r && (st_r == ST_OK);
  assign cnt_upd   = !ok_fin ? cnt_r : (req_r ? cnt_r - CntW'(1) : cnt_r + CntW'(1));
  assign left_over = last_r && (cnt_upd > CntW'(1));

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            req_r  <= in_ch.req_type;
            num_r  <= in_ch.number;
            op_r   <= in_ch.operator_char;
            last_r <= in_ch.last_token;
          end
        end
        S_RDR: rhs_r <= rdata;
        S_RDL: lhs_r <= rdata;
        S_EXEC: begin
          st_r      <= exec_st;
          res_r     <= exec_res;
          sat_r     <= exec_sat;
          neg_r     <= lhs_r[ValW-1] ^ rhs_r[ValW-1];
          prod_r    <= '0;
          mul_idx_r <= '0;
        end
        S_MUL: begin
          if (mul_idx_r != MulSteps) begin
            prod_r    <= prod_r + pp_sh;
            mul_idx_r <= mul_idx_r + 3'd1;
          end else begin
            {sat_r, res_r} <= sat_mag(neg_r, 97'(prod_r[MulW-1:FracBits]));
          end
        end
        S_DIV: if (div_done) begin
          {sat_r, res_r} <= div_ovf ? {1'b1, neg_r ? MinVal : MaxVal}
                                    : sat_mag(neg_r, 97'(div_q));
        end
        S_FIN: begin
          fin_o_r <= last_r;
          if (err_r) begin
            val_o_r <= '0;
            st_o_r  <= ST_OK;
          end else if (st_r != ST_OK) begin
            val_o_r <= '0;
            st_o_r  <= st_r;
          end else if (left_over) begin
            val_o_r <= '0;
            st_o_r  <= ST_LEFT;
          end else begin
            val_o_r <= res_r;
            st_o_r  <= sat_r ? ST_SAT : ST_OK;
          end
          cnt_r <= last_r ? '0 : cnt_upd;
          err_r <= !last_r && (err_r || (st_r != ST_OK));
        end
        default: ;
      endcase
    end
  end
endmodule

// File: hw/rtl/pse_stack_ram.sv
// Operand stack memory: one write port, one registered read port.
// Depends on pse_pkg.
`timescale 1ns / 1ps
module pse_stack_ram
  import pse_pkg::*;
(
  input  logic            clk,
  input  logic            we,
  input  logic [AddrW-1:0] waddr,
  input  logic [ValW-1:0] wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [ValW-1:0] rdata
);
  logic [ValW-1:0] mem [StackDepth];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/pse_divider.sv
// Restoring divider: ({|a|, FracBits zeros}) / |b|, one quotient bit a cycle.
// Depends on pse_pkg.
`timescale 1ns / 1ps
module pse_divider
  import pse_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [ValW-1:0] num_mag,
  input  logic [ValW-1:0] den_mag,
  output logic            done,
  output logic [ValW-1:0] quot,
  output logic            ovf
);
  localparam int DivW = ValW + FracBits;
  localparam int StepW = $clog2(DivW + 1);

  logic [DivW-1:0]  dvd_r;
  logic [ValW-1:0]  rem_r;
  logic [DivW-1:0]  q_r;
  logic [StepW-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [ValW:0]    trial;

  // the remainder stays below the divisor, so it fits in ValW bits
  assign trial = {rem_r, dvd_r[DivW-1]} - {1'b0, den_mag};

  // shift in one dividend bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= StepW'(DivW);
        dvd_r  <= DivW'(num_mag) << FracBits;
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        dvd_r <= dvd_r << 1;
        if (!trial[ValW]) begin
          rem_r <= trial[ValW-1:0];
          q_r   <= {q_r[DivW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[ValW-2:0], dvd_r[DivW-1]};
          q_r   <= {q_r[DivW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - StepW'(1);
        if (cnt_r == StepW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = q_r[ValW-1:0];
  assign ovf  = |q_r[DivW-1:ValW];
endmodule

// File: bench/tb_postfix_stack_evaluator_top.sv
// Testbench for postfix_stack_evaluator_top: drives token requests and checks each
// result against an in-bench stack predictor. Depends on pse_pkg, pse_if and the RTL.
`timescale 1ns / 1ps
module tb_postfix_stack_evaluator_top
  import pse_pkg::*;
();

  logic clk;
  logic rst_n;
  pse_in_if  in_ch();
  pse_out_if out_ch();

  postfix_stack_evaluator_top DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  typedef struct packed {
    logic [47:0] value;
    status_t     status;
    logic        final_res;
  } eval_result_t;

  localparam logic [96:0] MagLim = 97'h800000000000;
  localparam logic [7:0]  OpBadPct = 8'h25;
  localparam logic [7:0]  OpBadFf  = 8'hFF;

  // Predictor state
  logic signed [47:0] stk [StackDepth];
  int                 depth_used;
  bit                 err_held;
  eval_result_t       pending_q[$];
  int                 fails;
  longint             cycle_cnt;
  bit                 hold_off;
  int                 last_ops;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Build a saturated 48-bit value from sign and magnitude
  function automatic logic signed [47:0] saturate(input bit neg, input logic [96:0] mag,
                                                  inout bit sat);
    if (neg) begin
      if (mag > MagLim) begin
        sat = 1;
        return 48'sh800000000000;
      end
      return -$signed({1'b0, mag[47:0]});
    end
    if (mag > MagLim - 1) begin
      sat = 1;
      return 48'sh7FFFFFFFFFFF;
    end
    return mag[47:0];
  endfunction

  function automatic logic [96:0] magnitude(input logic signed [47:0] v);
    logic signed [48:0] w;
    w = v;
    return (w < 0) ? 97'(-w) : 97'(w);
  endfunction

  // Evaluate one token and update the predicted stack
  function automatic eval_result_t evaluate_token(input logic rt, input logic signed [31:0] num,
                                                  input logic [7:0] op, input logic lst);
    eval_result_t r;
    bit sat;
    logic signed [49:0] sum;
    logic signed [47:0] lhs, rhs, res;
    logic [96:0] m, la, ra;
    bit neg;
    sat = 0;
    res = '0;
    r.value = '0;
    r.status = ST_OK;
    r.final_res = lst;
    if (!err_held) begin
      if (rt == 1'b0) begin
        if (depth_used >= StackDepth) r.status = ST_FULL;
        else begin
          res = saturate(num < 0, magnitude(48'(num)) << FracBits, sat);
          stk[depth_used] = res;
          depth_used++;
          r.value = res;
        end
      end else if (depth_used < 2) begin
        r.status = ST_UNDER;
      end else begin
        rhs = stk[depth_used-1];
        lhs = stk[depth_used-2];
        la = magnitude(lhs);
        ra = magnitude(rhs);
        neg = (lhs < 0) != (rhs < 0);
        case (op)
          OpAdd, OpSub: begin
            sum = (op == OpAdd) ? 50'(lhs) + 50'(rhs) : 50'(lhs) - 50'(rhs);
            res = saturate(sum < 0, (sum < 0) ? 97'(-sum) : 97'(sum), sat);
          end
          OpMul: begin
            m = (la * ra) >> FracBits;
            res = saturate(neg, m, sat);
          end
          OpDiv: begin
            if (rhs == 0) r.status = ST_DIVZ;
            else res = saturate(neg, (la << FracBits) / ra, sat);
          end
          default: r.status = ST_BADOP;
        endcase
        if (r.status == ST_OK) begin
          depth_used--;
          stk[depth_used-1] = res;
          r.value = res;
        end
      end
      if (r.status != ST_OK) begin
        err_held = 1;
        r.value = '0;
      end else begin
        if (sat) r.status = ST_SAT;
        if (lst && depth_used > 1) begin
          r.status = ST_LEFT;
          r.value = '0;
        end
      end
    end
    if (lst) begin
      depth_used = 0;
      err_held = 0;
    end
    return r;
  endfunction

  // Send one request in a burst; the predictor runs at acceptance
  task automatic send_token(input logic rt, input logic signed [31:0] num,
                            input logic [7:0] op, input logic lst);
    in_ch.valid         <= 1'b1;
    in_ch.req_type      <= rt;
    in_ch.number        <= num;
    in_ch.operator_char <= op;
    in_ch.last_token    <= lst;
    do @(posedge clk); while (!in_ch.ready);
    pending_q.push_back(evaluate_token(rt, num, op, lst));
    // Random gap between bursts
    if ($urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic push_num(input logic signed [31:0] n, input logic lst = 0);
    send_token(1'b0, n, 8'($urandom), lst);
  endtask

  task automatic apply_op(input logic [7:0] op, input logic lst = 0);
    send_token(1'b1, $urandom, op, lst);
  endtask

  function automatic logic [7:0] pick_op();
    case ($urandom_range(0, 3))
      0: return OpAdd;
      1: return OpSub;
      2: return OpMul;
      default: return OpDiv;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_num();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 40)) - 20);
      2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  // Extremes, every operator, error cases and saturation
  task automatic test_directed();
    push_num(32'h7FFFFFFF);
    push_num(32'h80000000);
    apply_op(OpAdd);
    push_num(7);
    apply_op(OpSub, 1);
    push_num(-6); push_num(4); apply_op(OpMul);
    push_num(3); apply_op(OpDiv, 1);
    push_num(32'h7FFFFFFF); push_num(32'h7FFFFFFF); apply_op(OpMul, 1);
    push_num(5); push_num(0); apply_op(OpDiv); push_num(1, 1);
    apply_op(OpBadPct, 1);
    push_num(1); push_num(2); apply_op(OpBadFf); apply_op(OpAdd, 1);
    push_num(9); push_num(9, 1);
    push_num(32'h80000000); push_num(1); apply_op(OpDiv, 1);
  endtask

  // Fill the stack to the top, then one push too many
  task automatic test_stack_full();
    repeat (StackDepth) push_num(pick_num());
    push_num(1);
    push_num(2, 1);
  endtask

  // Well-formed expressions with random content, plus some broken ones
  task automatic test_random_expressions(input int n_tokens);
    int sent, live, target;
    sent = 0;
    while (sent < n_tokens) begin
      if ($urandom_range(0, 9) == 0) begin
        send_token(1'($urandom), pick_num(), 8'($urandom), $urandom_range(0, 3) == 0);
        sent++;
        continue;
      end
      target = $urandom_range(1, 6);
      push_num(pick_num());
      sent++;
      live = 1;
      while (live < target) begin
        push_num(pick_num());
        live++;
        sent++;
        if (live > 1 && $urandom_range(0, 1)) begin
          apply_op(pick_op());
          live--;
          sent++;
        end
      end
      while (live > 2) begin
        apply_op(pick_op());
        live--;
        sent++;
      end
      if (live == 2) apply_op(pick_op(), 1);
      else push_num(pick_num(), 1);
      sent++;
    end
  endtask

  // Receiver stall pattern, with one long hold-off
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) out_ch.ready <= 1'b0;
      else out_ch.ready <= (cycle_cnt % 64 < 40) ? 1'b1 : ($urandom_range(0, 2) != 0);
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    eval_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        $error("result with no request pending: value %h", out_ch.value);
        fails++;
      end else begin
        e = pending_q.pop_front();
        if (out_ch.value !== e.value) begin
          $error("value expected %h actual %h", e.value, out_ch.value);
          fails++;
        end
        if (out_ch.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_ch.status);
          fails++;
        end
        if (out_ch.final_res !== e.final_res) begin
          $error("final_res expected %0d actual %0d", e.final_res, out_ch.final_res);
          fails++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 600000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int hold_cycles;
    cycle_cnt = 0;
    fails = 0;
    depth_used = 0;
    err_held = 0;
    hold_off = 0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.req_type <= 1'b0;
    in_ch.number <= '0;
    in_ch.operator_char <= '0;
    in_ch.last_token <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_stack_full();
    // Long receiver hold-off while requests keep coming
    fork
      begin
        hold_off = 1;
        for (hold_cycles = 0; hold_cycles < 400; hold_cycles++) @(posedge clk);
        hold_off = 0;
      end
      test_random_expressions(20);
    join
    test_random_expressions(830);
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
